// ===== sv/utf8_stream_decoder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_UNIT_DEFINES_SVH
`define UTF8_STREAM_DECODER_UNIT_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define U8SD_CHECK(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define U8SD_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== sv/u8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Payload types and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u8sd_pkg;

    localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] MAX_CODE    = 21'h10FFFF;
    localparam logic [20:0] MIN_LEN2    = 21'h000080;
    localparam logic [20:0] MIN_LEN3    = 21'h000800;
    localparam logic [20:0] MIN_LEN4    = 21'h010000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } byte_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  byte_count;
        logic        last_of_run;
    } result_t;

    // Results caused by one byte: r0 always, r1 only when two is set.
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } job_t;

endpackage

`default_nettype wire

// ===== sv/u8sd_front.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder front end
// Accepts bytes, tracks the open sequence and builds the result jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8sd_front
    import u8sd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  accept,
    input  wire byte_t byte_data,
    output logic       push,
    output job_t       job
);

    logic [1:0]  rem_reg, rem_next;
    logic [20:0] pv_reg, pv_next;
    logic [2:0]  taken_reg, taken_next;
    logic [1:0]  seqlen_reg, seqlen_next;

    logic [7:0]  b;
    logic        eob;
    logic        cont;
    logic        fresh_emit;
    logic [20:0] fresh_cp;
    logic [20:0] open_pv;
    logic [1:0]  open_len;
    logic [20:0] ext_pv;
    logic [2:0]  ext_taken;
    logic [1:0]  ext_rem;
    logic [20:0] min_val;
    logic [20:0] done_cp;

    assign b    = byte_data.data_byte;
    assign eob  = byte_data.end_of_buffer;
    assign cont = (b[7:6] == 2'b10);

    // Decode the byte as if no sequence were open.
    always_comb
    begin
        fresh_emit = 1'b1;
        fresh_cp   = REPLACEMENT;
        open_pv    = '0;
        open_len   = 2'd0;
        if (b < 8'h80)
        begin
            fresh_cp = {13'd0, b};
        end
        else if (b < 8'hC2 || b > 8'hF4 || eob)
        begin
            fresh_cp = REPLACEMENT;
        end
        else
        begin
            fresh_emit = 1'b0;
            if (b < 8'hE0)
            begin
                open_pv  = {16'd0, b[4:0]};
                open_len = 2'd1;
            end
            else if (b < 8'hF0)
            begin
                open_pv  = {17'd0, b[3:0]};
                open_len = 2'd2;
            end
            else
            begin
                open_pv  = {18'd0, b[2:0]};
                open_len = 2'd3;
            end
        end
    end

    assign ext_pv    = {pv_reg[14:0], b[5:0]};
    assign ext_taken = taken_reg + 3'd1;
    assign ext_rem   = rem_reg - 2'd1;

    always_comb
    begin
        unique case (seqlen_reg)
            2'd1:    min_val = MIN_LEN2;
            2'd2:    min_val = MIN_LEN3;
            default: min_val = MIN_LEN4;
        endcase
    end

    assign done_cp = (ext_pv < min_val || ext_pv > MAX_CODE) ? REPLACEMENT : ext_pv;

    always_comb
    begin
        rem_next    = rem_reg;
        pv_next     = pv_reg;
        taken_next  = taken_reg;
        seqlen_next = seqlen_reg;
        push        = 1'b0;
        job         = '0;
        if (accept)
        begin
            if (rem_reg != 2'd0 && cont)
            begin
                rem_next   = ext_rem;
                pv_next    = ext_pv;
                taken_next = ext_taken;
                if (ext_rem == 2'd0 || eob)
                begin
                    push              = 1'b1;
                    job.r0.code_point = (ext_rem == 2'd0) ? done_cp : REPLACEMENT;
                    job.r0.byte_count = ext_taken;
                    job.r0.last_of_run = 1'b1;
                    rem_next    = 2'd0;
                    pv_next     = '0;
                    taken_next  = 3'd0;
                    seqlen_next = 2'd0;
                end
            end
            else
            begin
                // Close any interrupted sequence, then take the byte afresh.
                rem_next    = open_len;
                pv_next     = open_pv;
                taken_next  = fresh_emit ? 3'd0 : 3'd1;
                seqlen_next = open_len;
                push        = (rem_reg != 2'd0) || fresh_emit;
                if (rem_reg != 2'd0)
                begin
                    job.two            = fresh_emit;
                    job.r0.code_point  = REPLACEMENT;
                    job.r0.byte_count  = taken_reg;
                    job.r0.last_of_run = !fresh_emit;
                    job.r1.code_point  = fresh_cp;
                    job.r1.byte_count  = 3'd1;
                    job.r1.last_of_run = 1'b1;
                end
                else
                begin
                    job.r0.code_point  = fresh_cp;
                    job.r0.byte_count  = 3'd1;
                    job.r0.last_of_run = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= 2'd0;
            pv_reg     <= '0;
            taken_reg  <= 3'd0;
            seqlen_reg <= 2'd0;
        end
        else
        begin
            rem_reg    <= rem_next;
            pv_reg     <= pv_next;
            taken_reg  <= taken_next;
            seqlen_reg <= seqlen_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/u8sd_fifo.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder job queue
// Short register queue between the front end and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_unit_defines.svh"

module u8sd_fifo
    import u8sd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output logic      full,
    output logic      not_empty,
    output job_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `U8SD_CHECK(a_no_overflow, !(push && full), "job pushed into a full queue")
    `U8SD_CHECK(a_count_range, count_reg <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

`default_nettype wire

// ===== sv/u8sd_back.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder output stage
// Unpacks jobs into single results and holds them in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_unit_defines.svh"

module u8sd_back
    import u8sd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_avail,
    input  wire job_t job,
    output logic      pop,
    output logic      valid,
    input  wire logic ready,
    output result_t   data
);

    result_t out_reg;
    result_t sec_reg;
    logic    out_valid_reg;
    logic    sec_valid_reg;
    logic    take;
    logic    can_load;

    assign take     = out_valid_reg && ready;
    assign can_load = !out_valid_reg || (take && !sec_valid_reg);
    assign pop      = can_load && job_avail;
    assign valid    = out_valid_reg;
    assign data     = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end
        else if (take && sec_valid_reg)
        begin
            // Advance to the held second result.
            sec_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
            sec_valid_reg <= job.two;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && sec_valid_reg)
        begin
            out_reg <= sec_reg;
        end
        else if (pop)
        begin
            out_reg <= job.r0;
            sec_reg <= job.r1;
        end
    end

    `U8SD_CHECK(a_second_needs_first, !sec_valid_reg || out_valid_reg,
                "second result held without a first")
    `U8SD_CHECK(a_first_not_last, !sec_valid_reg || !out_reg.last_of_run,
                "first of two results marked last")
    `U8SD_NEXT(a_second_follows, take && sec_valid_reg,
               out_valid_reg && out_reg.last_of_run, "second result did not follow")

endmodule

`default_nettype wire

// ===== sv/utf8_stream_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes a byte stream into code points with their byte counts.
//
//   channel   dir  handshake                 payload
//   byte      in   byte_valid / byte_ready   byte_data (data_byte, end_of_buffer)
//   cp        out  cp_valid / cp_ready       cp_data (code_point, byte_count,
//                                             last_of_run)
//
// One byte is accepted per cycle while the job queue has room.
// A byte that closes an interrupted sequence and is itself a result yields
// two results; the output register sends one per cycle while cp_ready is set.
// Each result is registered in the job queue and then in the output register.
// Reset clears the sequence state, the queue and the output register.
// Output stalls back up through the QUEUE_DEPTH-entry queue to byte_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder_unit
    import u8sd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  byte_valid,
    output logic       byte_ready,
    input  wire byte_t byte_data,
    output logic       cp_valid,
    input  wire logic  cp_ready,
    output result_t    cp_data
);

    logic accept;
    logic push;
    job_t push_job;
    logic pop;
    logic full;
    logic not_empty;
    job_t head;

    assign byte_ready = !full;
    assign accept     = byte_valid && byte_ready;

    u8sd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .byte_data (byte_data),
        .push      (push),
        .job       (push_job)
    );

    u8sd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    u8sd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (not_empty),
        .job       (head),
        .pop       (pop),
        .valid     (cp_valid),
        .ready     (cp_ready),
        .data      (cp_data)
    );

endmodule

`default_nettype wire

// ===== dv/utf8_stream_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Sends byte transactions into the decoder and checks every code point
// transaction against a behavioral decoder kept in step with the accepted
// bytes. Directed cases cover single bytes, well-formed and invalid sequences
// and cut-off sequences. Random phases follow, most of them well-formed
// characters mixed with noise and broken sequences, under several idle and
// stall settings and one long output hold-off.
// ----------------------------------------------------------------------------

module utf8_stream_decoder_unit_tb;

    import u8sd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_BYTES  = 180;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    byte_valid = 1'b0;
    logic    byte_ready;
    byte_t   byte_data = '0;
    logic    cp_valid;
    logic    cp_ready = 1'b0;
    result_t cp_data;

    // Behavioral decoder state
    logic [1:0]  open_left;
    logic [20:0] open_value;
    logic [2:0]  open_taken;
    logic [1:0]  open_len;

    result_t pending_cps [$];
    int      errors = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_cycles = 0;
    int      bytes_sent = 0;

    utf8_stream_decoder_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .cp_valid   (cp_valid),
        .cp_ready   (cp_ready),
        .cp_data    (cp_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("utf8_stream_decoder_unit_tb NOT OK");
            $finish;
        end
    end

    function automatic void clear_open();
        open_left  = 2'd0;
        open_value = 21'd0;
        open_taken = 3'd0;
        open_len   = 2'd0;
    endfunction

    // Advance the decoder by one byte and queue the code points it yields.
    function automatic void decode_byte(input logic [7:0] b, input logic eob);
        result_t     outs [2];
        int          n;
        logic        consumed;
        logic [20:0] floor_value;
        n = 0;
        consumed = 1'b0;
        if (open_left != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                consumed   = 1'b1;
                open_value = {open_value[14:0], b[5:0]};
                open_taken = open_taken + 3'd1;
                open_left  = open_left - 2'd1;
                if (open_left == 2'd0)
                begin
                    case (open_len)
                        2'd1:    floor_value = MIN_LEN2;
                        2'd2:    floor_value = MIN_LEN3;
                        default: floor_value = MIN_LEN4;
                    endcase
                    outs[0].code_point = (open_value < floor_value || open_value > MAX_CODE)
                                         ? REPLACEMENT : open_value;
                    outs[0].byte_count = open_taken;
                    outs[0].last_of_run = 1'b0;
                    n = 1;
                end
                else if (eob)
                begin
                    outs[0] = '{REPLACEMENT, open_taken, 1'b0};
                    n = 1;
                end
                if (n != 0)
                    clear_open();
            end
            else
            begin
                // Close the interrupted sequence, then decode this byte afresh.
                outs[0] = '{REPLACEMENT, open_taken, 1'b0};
                n = 1;
                clear_open();
            end
        end
        if (!consumed)
        begin
            if (b < 8'h80)
            begin
                outs[n] = '{{13'd0, b}, 3'd1, 1'b0};
                n++;
            end
            else if (b < 8'hC2 || b > 8'hF4 || eob)
            begin
                outs[n] = '{REPLACEMENT, 3'd1, 1'b0};
                n++;
            end
            else
            begin
                if (b < 8'hE0)
                begin
                    open_value = {16'd0, b[4:0]};
                    open_len   = 2'd1;
                end
                else if (b < 8'hF0)
                begin
                    open_value = {17'd0, b[3:0]};
                    open_len   = 2'd2;
                end
                else
                begin
                    open_value = {18'd0, b[2:0]};
                    open_len   = 2'd3;
                end
                open_left  = open_len;
                open_taken = 3'd1;
            end
        end
        if (n > 0)
            outs[n - 1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            pending_cps.push_back(outs[i]);
    endfunction

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            cp_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
            cp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && cp_valid && cp_ready)
        begin
            if (pending_cps.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction, actual cp=%h count=%0d last=%b",
                         $time, cp_data.code_point, cp_data.byte_count,
                         cp_data.last_of_run);
            end
            else
            begin
                want = pending_cps.pop_front();
                if (cp_data.code_point !== want.code_point)
                begin
                    errors++;
                    $display("%0t: code_point expected %h actual %h",
                             $time, want.code_point, cp_data.code_point);
                end
                if (cp_data.byte_count !== want.byte_count)
                begin
                    errors++;
                    $display("%0t: byte_count expected %0d actual %0d",
                             $time, want.byte_count, cp_data.byte_count);
                end
                if (cp_data.last_of_run !== want.last_of_run)
                begin
                    errors++;
                    $display("%0t: last_of_run expected %b actual %b",
                             $time, want.last_of_run, cp_data.last_of_run);
                end
            end
        end
    end

    // Entered and left at a falling edge; valid stays high into a back-to-back send.
    task automatic send_byte(input logic [7:0] b, input logic eob);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= '{b, eob};
        do
            @(posedge clk);
        while (byte_ready !== 1'b1);
        decode_byte(b, eob);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        byte_valid <= 1'b0;
        while (pending_cps.size() != 0)
            @(negedge clk);
    endtask

    // One character: mostly well-formed, else overlong, too large, cut short or noise.
    task automatic send_random_char();
        logic [7:0]  enc [4];
        logic [20:0] v;
        int          kind;
        int          len;
        int          count;
        logic        eob;
        kind = $urandom_range(99);
        len = $urandom_range(1, 4);
        case (len)
            1:       v = 21'($urandom_range(21'h0, 21'h7F));
            2:       v = 21'($urandom_range(21'h80, 21'h7FF));
            3:       v = 21'($urandom_range(21'h800, 21'hFFFF));
            default: v = 21'($urandom_range(21'h10000, 21'h10FFFF));
        endcase
        if (kind >= 55 && kind < 65)
        begin
            len = $urandom_range(2, 4);
            case (len)
                2:       v = 21'($urandom_range(0, 21'h7F));
                3:       v = 21'($urandom_range(0, 21'h7FF));
                default: v = 21'($urandom_range(0, 21'hFFFF));
            endcase
        end
        else if (kind >= 65 && kind < 72)
        begin
            len = 4;
            v = 21'($urandom_range(21'h110000, 21'h1FFFFF));
        end
        else if (kind >= 72 && kind < 87 && len == 1)
            len = 2;
        case (len)
            1:
            begin
                enc[0] = {1'b0, v[6:0]};
            end
            2:
            begin
                enc[0] = {3'b110, v[10:6]};
                enc[1] = {2'b10, v[5:0]};
            end
            3:
            begin
                enc[0] = {4'b1110, v[15:12]};
                enc[1] = {2'b10, v[11:6]};
                enc[2] = {2'b10, v[5:0]};
            end
            default:
            begin
                enc[0] = {5'b11110, v[20:18]};
                enc[1] = {2'b10, v[17:12]};
                enc[2] = {2'b10, v[11:6]};
                enc[3] = {2'b10, v[5:0]};
            end
        endcase
        count = len;
        if (kind >= 72 && kind < 87)
            count = $urandom_range(1, len - 1);
        else if (kind >= 87)
        begin
            enc[0] = 8'($urandom_range(0, 255));
            count = 1;
        end
        for (int i = 0; i < count; i++)
        begin
            eob = (i == count - 1) ? ($urandom_range(99) < 8) : ($urandom_range(99) < 2);
            send_byte(enc[i], eob);
        end
    endtask

    task automatic test_single_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hC1, 1'b0);
        send_byte(8'hF5, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_well_formed();
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // Surrogate range decodes as an ordinary value
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    task automatic test_bad_values();
        send_byte(8'hE0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    task automatic test_cut_sequences();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hC3, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
    endtask

    task automatic test_random(input int send_pct, input int recv_pct, input int n_bytes);
        int stop_at;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
            send_random_char();
        // Pause the sender until every code point has come out
        wait_drained();
    endtask

    task automatic test_output_hold_off();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        hold_cycles = 300;
        @(negedge clk);
        repeat (20)
            send_random_char();
        wait_drained();
    endtask

    initial
    begin
        clear_open();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_single_bytes();
        test_well_formed();
        test_bad_values();
        test_cut_sequences();
        wait_drained();

        test_random(0, 0, PHASE_BYTES);
        test_random(88, 0, PHASE_BYTES);
        test_random(0, 88, PHASE_BYTES);
        test_random(35, 35, PHASE_BYTES);
        test_output_hold_off();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("utf8_stream_decoder_unit_tb OK");
        else
            $display("utf8_stream_decoder_unit_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/u8sd_pkg.sv
sv/u8sd_front.sv
sv/u8sd_fifo.sv
sv/u8sd_back.sv
sv/utf8_stream_decoder_unit.sv
dv/utf8_stream_decoder_unit_tb.sv
